/* rtl/hng_pkg.sv */
// Package for the hysteresis noise gate: widths, reset values, register
// indexes, state and command types, and the saturation helper.
// No dependencies.
package hng_pkg;

   localparam int SAMPLE_W  = 24;                 // Q1.23 samples
   localparam int COEF_W    = 24;                 // Q0.24 coefficients
   localparam int GAIN_FRAC = 24;                 // gain is Q1.24
   localparam int GAIN_W    = GAIN_FRAC + 1;      // 0 .. 2^24
   localparam int ENV_W     = SAMPLE_W - 1;       // envelope is never negative
   localparam int DIFF_W    = GAIN_W + 1;         // widest signed difference
   localparam int MAG_W     = GAIN_W;             // magnitude of a difference
   localparam int OPB_W     = GAIN_W;             // coefficient or gain operand
   localparam int PROD_W    = MAG_W + OPB_W;
   localparam int RND_W     = PROD_W - COEF_W;    // rounded product
   localparam int DELTA_W   = RND_W + 1;          // signed step
   localparam int CSR_IDX_W = 3;

   // close level: 0.00045 of full scale in Q0.31, rounded to the sample grid
   localparam int CLOSE_Q31 = 966368;
   localparam int CLOSE_SH  = 32 - SAMPLE_W;

   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (COEF_W - 1);
   localparam logic [ENV_W-1:0]  ENV_MAX    = {ENV_W{1'b1}};
   localparam logic [ENV_W-1:0]  CLOSE_THRESHOLD =
      ENV_W'((CLOSE_Q31 + ((1 << CLOSE_SH) >> 1)) >> CLOSE_SH);
   localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(1) << GAIN_FRAC;

   localparam logic              RST_GATE_ENABLE = 1'b1;
   localparam logic [COEF_W-1:0] RST_HP_COEF     = COEF_W'(216770);
   localparam logic [COEF_W-1:0] RST_LP_COEF     = COEF_W'(4953342);
   localparam logic [COEF_W-1:0] RST_ATTACK_COEF = COEF_W'(231404);
   localparam logic [COEF_W-1:0] RST_RELEASE_COEF = COEF_W'(1589);
   localparam logic [COEF_W-1:0] RST_OPEN_COEF   = COEF_W'(345898);
   localparam logic [COEF_W-1:0] RST_CLOSE_COEF  = COEF_W'(1942);
   localparam logic [ENV_W-1:0]  RST_OPEN_THRESHOLD = ENV_W'(8389);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GATE_ENABLE    = 3'd0,
      CSR_HP_COEF        = 3'd1,
      CSR_LP_COEF        = 3'd2,
      CSR_ATTACK_COEF    = 3'd3,
      CSR_RELEASE_COEF   = 3'd4,
      CSR_OPEN_COEF      = 3'd5,
      CSR_CLOSE_COEF     = 3'd6,
      CSR_OPEN_THRESHOLD = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic              gate_enable;
      logic [COEF_W-1:0] hp_coef;
      logic [COEF_W-1:0] lp_coef;
      logic [COEF_W-1:0] attack_coef;
      logic [COEF_W-1:0] release_coef;
      logic [COEF_W-1:0] open_coef;
      logic [COEF_W-1:0] close_coef;
      logic [ENV_W-1:0]  open_threshold;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_UPD,
      ST_OUT
   } state_type;

   // one pass of the shared multiplier
   typedef enum logic [2:0] {
      OP_HP,
      OP_LP,
      OP_ENV,
      OP_GAIN,
      OP_OUT
   } op_type;

   typedef struct packed {
      logic   load;       // take the input item
      logic   prep;       // form operands for op
      logic   mul;        // register the product
      logic   upd;        // round and apply the step
      logic   out_load;   // move result into the output register
      op_type op;
   } cmd_type;

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [DELTA_W-1:0] v);
      logic signed [DELTA_W-1:0] hi;
      logic signed [DELTA_W-1:0] lo;
      hi = DELTA_W'((1 <<< (SAMPLE_W - 1)) - 1);
      lo = -hi - DELTA_W'(1);
      if (v > hi)      sat_sample = hi[SAMPLE_W-1:0];
      else if (v < lo) sat_sample = lo[SAMPLE_W-1:0];
      else             sat_sample = v[SAMPLE_W-1:0];
   endfunction

endpackage

/* rtl/hysteresis_noise_gate_core.sv */
// Top level of the hysteresis noise gate.
// Depends on hng_pkg, hng_csr, hng_ctrl and hng_dp.
//
// Use:
//  - req_ channel carries one item: sidechain sample (detection) and audio
//    sample, both Q1.23. rsp_ channel returns the gated audio sample in
//    tdata and the gate open flag after this item in tuser.
//  - csr_ channel writes one register per handshake; csr_ready is always
//    high. Write only while the block is idle.
//  - One item at a time. Gating: an item takes five passes through one
//    shared 25x25 multiplier (operand, product, rounded update per pass);
//    rsp_tvalid rises once the result is in the output register, and only
//    then can the next item be taken. Gate disabled: the audio sample is
//    passed through to the output register, state held.
//  - The result sits in an output register, so a new item is accepted while
//    an earlier result waits; if the receiver still stalls when the next
//    result is ready, the sequencer holds and req_tready stays low.
//  - Synchronous reset restores register defaults, clears the filters,
//    envelope and gain, closes the gate and drops rsp_tvalid.
module hysteresis_noise_gate_core (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: [23:0] sidechain_sample, [47:24] audio_sample
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [2*hng_pkg::SAMPLE_W-1:0]    req_tdata,
   // rsp_tdata: [23:0] gated_sample
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [hng_pkg::SAMPLE_W-1:0]      rsp_tdata,
   // rsp_tuser: [0] gate_is_open
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hng_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hng_pkg::COEF_W-1:0]        csr_data
);

   hng_pkg::cfg_type cfg;
   hng_pkg::cmd_type cmd;
   logic signed [hng_pkg::SAMPLE_W-1:0] gated;

   assign csr_ready = 1'b1;

   hng_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hng_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .gate_enable (cfg.gate_enable),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .cmd         (cmd)
   );

   hng_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .sidechain_sample (req_tdata[hng_pkg::SAMPLE_W-1:0]),
      .audio_sample     (req_tdata[2*hng_pkg::SAMPLE_W-1:hng_pkg::SAMPLE_W]),
      .gated_sample     (gated),
      .gate_is_open     (rsp_tuser)
   );

   assign rsp_tdata = gated;

endmodule

/* rtl/hng_csr.sv */
// Configuration register file of the noise gate.
// Depends on hng_pkg.
module hng_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [hng_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hng_pkg::COEF_W-1:0]    csr_data,
   output hng_pkg::cfg_type              cfg
);

   hng_pkg::cfg_type cfg_ff;
   hng_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (hng_pkg::csr_idx_type'(csr_index))
            hng_pkg::CSR_GATE_ENABLE:    cfg_in.gate_enable    = csr_data[0];
            hng_pkg::CSR_HP_COEF:        cfg_in.hp_coef        = csr_data;
            hng_pkg::CSR_LP_COEF:        cfg_in.lp_coef        = csr_data;
            hng_pkg::CSR_ATTACK_COEF:    cfg_in.attack_coef    = csr_data;
            hng_pkg::CSR_RELEASE_COEF:   cfg_in.release_coef   = csr_data;
            hng_pkg::CSR_OPEN_COEF:      cfg_in.open_coef      = csr_data;
            hng_pkg::CSR_CLOSE_COEF:     cfg_in.close_coef     = csr_data;
            hng_pkg::CSR_OPEN_THRESHOLD:
               cfg_in.open_threshold = csr_data[hng_pkg::ENV_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gate_enable    <= hng_pkg::RST_GATE_ENABLE;
         cfg_ff.hp_coef        <= hng_pkg::RST_HP_COEF;
         cfg_ff.lp_coef        <= hng_pkg::RST_LP_COEF;
         cfg_ff.attack_coef    <= hng_pkg::RST_ATTACK_COEF;
         cfg_ff.release_coef   <= hng_pkg::RST_RELEASE_COEF;
         cfg_ff.open_coef      <= hng_pkg::RST_OPEN_COEF;
         cfg_ff.close_coef     <= hng_pkg::RST_CLOSE_COEF;
         cfg_ff.open_threshold <= hng_pkg::RST_OPEN_THRESHOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/hng_ctrl.sv */
// Sequencer of the noise gate: walks the five multiplier passes and owns
// the output valid. Depends on hng_pkg.
module hng_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              gate_enable,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output hng_pkg::cmd_type  cmd
);

   hng_pkg::state_type state_ff, state_in;
   hng_pkg::op_type    op_ff, op_in, op_succ;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      unique case (op_ff)
         hng_pkg::OP_HP:   op_succ = hng_pkg::OP_LP;
         hng_pkg::OP_LP:   op_succ = hng_pkg::OP_ENV;
         hng_pkg::OP_ENV:  op_succ = hng_pkg::OP_GAIN;
         hng_pkg::OP_GAIN: op_succ = hng_pkg::OP_OUT;
         default:          op_succ = hng_pkg::OP_HP;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      unique case (state_ff)
         hng_pkg::ST_IDLE: begin
            op_in = hng_pkg::OP_HP;
            if (req_tvalid) state_in = gate_enable ? hng_pkg::ST_PREP : hng_pkg::ST_OUT;
         end
         hng_pkg::ST_PREP: state_in = hng_pkg::ST_MUL;
         hng_pkg::ST_MUL:  state_in = hng_pkg::ST_UPD;
         hng_pkg::ST_UPD: begin
            if (op_ff == hng_pkg::OP_OUT) begin
               state_in = hng_pkg::ST_OUT;
            end else begin
               state_in = hng_pkg::ST_PREP;
               op_in    = op_succ;
            end
         end
         hng_pkg::ST_OUT: if (rsp_free) state_in = hng_pkg::ST_IDLE;
         default: state_in = hng_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.op       = op_ff;
      req_tready   = 1'b0;
      unique case (state_ff)
         hng_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         hng_pkg::ST_PREP: cmd.prep     = 1'b1;
         hng_pkg::ST_MUL:  cmd.mul      = 1'b1;
         hng_pkg::ST_UPD:  cmd.upd      = 1'b1;
         hng_pkg::ST_OUT:  cmd.out_load = rsp_free;
         default: ;
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hng_pkg::ST_IDLE;
         op_ff        <= hng_pkg::OP_HP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/hng_dp.sv */
// Datapath of the noise gate: filter, envelope and gain state, one shared
// multiplier with rounding, and the output register. Depends on hng_pkg.
module hng_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  hng_pkg::cfg_type                    cfg,
   input  hng_pkg::cmd_type                    cmd,
   input  logic signed [hng_pkg::SAMPLE_W-1:0] sidechain_sample,
   input  logic signed [hng_pkg::SAMPLE_W-1:0] audio_sample,
   output logic signed [hng_pkg::SAMPLE_W-1:0] gated_sample,
   output logic                                gate_is_open
);

   localparam int SW = hng_pkg::SAMPLE_W;
   localparam int DW = hng_pkg::DIFF_W;
   localparam int EW = hng_pkg::ENV_W;
   localparam int GW = hng_pkg::GAIN_W;
   localparam int TW = hng_pkg::DELTA_W + 1;   // track plus step

   logic signed [SW-1:0] x_ff, audio_ff;
   logic signed [SW-1:0] hp_track_ff, hp_track_in;
   logic signed [SW-1:0] lp_track_ff, lp_track_in;
   logic [EW-1:0]        env_ff, env_in;
   logic [GW-1:0]        gain_ff, gain_in;
   logic                 open_ff, open_in, flag_next;
   logic signed [SW-1:0] result_ff, result_in;
   logic signed [SW-1:0] rsp_sample_ff;
   logic                 rsp_open_ff;

   logic                            sign_ff, sign_in;
   logic [hng_pkg::MAG_W-1:0]       mag_ff, mag_in;
   logic [hng_pkg::OPB_W-1:0]       opb_ff, opb_in;
   logic [hng_pkg::PROD_W-1:0]      prod_ff;

   logic signed [DW-1:0] diff, hp_diff, lp_abs;
   logic signed [SW-1:0] hp_sat;
   logic [EW-1:0]        level;
   logic [GW-1:0]        target;
   logic [hng_pkg::PROD_W-1:0] prod_rnd;
   logic [hng_pkg::RND_W-1:0]  rnd;
   logic signed [hng_pkg::DELTA_W-1:0] delta;
   logic signed [TW-1:0] hp_sum, lp_sum, env_sum, gain_sum;

   // operand forming
   always_comb begin
      hp_diff = DW'(x_ff) - DW'(hp_track_ff);
      hp_sat  = hng_pkg::sat_sample(hng_pkg::DELTA_W'(hp_diff));
      lp_abs  = lp_track_ff[SW-1] ? -DW'(lp_track_ff) : DW'(lp_track_ff);
      level   = (lp_abs > DW'(hng_pkg::ENV_MAX)) ? hng_pkg::ENV_MAX : lp_abs[EW-1:0];

      flag_next = open_ff;
      if (!open_ff) begin
         if (env_ff >= cfg.open_threshold) flag_next = 1'b1;
      end else begin
         if (env_ff < hng_pkg::CLOSE_THRESHOLD) flag_next = 1'b0;
      end
      target = flag_next ? hng_pkg::GAIN_ONE : '0;

      diff   = '0;
      opb_in = opb_ff;
      unique case (cmd.op)
         hng_pkg::OP_HP: begin
            diff   = hp_diff;
            opb_in = hng_pkg::OPB_W'(cfg.hp_coef);
         end
         hng_pkg::OP_LP: begin
            diff   = DW'(hp_sat) - DW'(lp_track_ff);
            opb_in = hng_pkg::OPB_W'(cfg.lp_coef);
         end
         hng_pkg::OP_ENV: begin
            diff   = DW'({1'b0, level}) - DW'({1'b0, env_ff});
            opb_in = hng_pkg::OPB_W'((level > env_ff) ? cfg.attack_coef : cfg.release_coef);
         end
         hng_pkg::OP_GAIN: begin
            diff   = DW'({1'b0, target}) - DW'({1'b0, gain_ff});
            opb_in = hng_pkg::OPB_W'((target > gain_ff) ? cfg.open_coef : cfg.close_coef);
         end
         hng_pkg::OP_OUT: begin
            diff   = DW'(audio_ff);
            opb_in = gain_ff;
         end
         default: ;
      endcase
      sign_in = diff[DW-1];
      mag_in  = diff[DW-1] ? hng_pkg::MAG_W'(-diff) : hng_pkg::MAG_W'(diff);
   end

   // rounding half away from zero on the magnitude, then the sign back
   assign prod_rnd = prod_ff + hng_pkg::ROUND_HALF;
   assign rnd      = prod_rnd[hng_pkg::PROD_W-1:hng_pkg::COEF_W];
   assign delta    = sign_ff ? -hng_pkg::DELTA_W'(rnd) : hng_pkg::DELTA_W'(rnd);

   assign hp_sum   = TW'(hp_track_ff) + TW'(delta);
   assign lp_sum   = TW'(lp_track_ff) + TW'(delta);
   assign env_sum  = TW'({1'b0, env_ff}) + TW'(delta);
   assign gain_sum = TW'({1'b0, gain_ff}) + TW'(delta);

   always_comb begin
      hp_track_in = hp_track_ff;
      lp_track_in = lp_track_ff;
      env_in      = env_ff;
      gain_in     = gain_ff;
      open_in     = open_ff;
      result_in   = result_ff;
      if (cmd.load) result_in = audio_sample;   // pass-through unless gated
      if (cmd.prep && cmd.op == hng_pkg::OP_GAIN) open_in = flag_next;
      if (cmd.upd) begin
         unique case (cmd.op)
            hng_pkg::OP_HP:   hp_track_in = hp_sum[SW-1:0];
            hng_pkg::OP_LP:   lp_track_in = lp_sum[SW-1:0];
            hng_pkg::OP_ENV:  env_in      = env_sum[EW-1:0];
            hng_pkg::OP_GAIN: gain_in     = gain_sum[GW-1:0];
            hng_pkg::OP_OUT:  result_in   = hng_pkg::sat_sample(delta);
            default: ;
         endcase
      end
   end

   // gate state
   always_ff @(posedge clock) begin
      if (reset) begin
         hp_track_ff <= '0;
         lp_track_ff <= '0;
         env_ff      <= '0;
         gain_ff     <= '0;
         open_ff     <= 1'b0;
      end else begin
         hp_track_ff <= hp_track_in;
         lp_track_ff <= lp_track_in;
         env_ff      <= env_in;
         gain_ff     <= gain_in;
         open_ff     <= open_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff     <= sidechain_sample;
         audio_ff <= audio_sample;
      end
      result_ff <= result_in;
      if (cmd.prep) begin
         sign_ff <= sign_in;
         mag_ff  <= mag_in;
         opb_ff  <= opb_in;
      end
      if (cmd.mul) prod_ff <= mag_ff * opb_ff;
      if (cmd.out_load) begin
         rsp_sample_ff <= result_ff;
         rsp_open_ff   <= open_ff;
      end
   end

   assign gated_sample = rsp_sample_ff;
   assign gate_is_open = rsp_open_ff;

endmodule

/* rtl/hng_checker.sv */
// Port-level checks of the noise gate, bound to the top level.
// Depends on hng_pkg and hysteresis_noise_gate_core.
module hng_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [hng_pkg::SAMPLE_W-1:0]      rsp_tdata,
   input logic                              rsp_tuser
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while busy");

   // a new result only appears from the busy sequencer
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result raised while idle");

   // reset empties the output
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("output not clear after reset");

endmodule

bind hysteresis_noise_gate_core hng_checker u_hng_checker (.*);

/* tb/hysteresis_noise_gate_core_tb.sv */
// Self-checking testbench for hysteresis_noise_gate_core: a directed table, then phased
// random items, each checked against a bit-true gate predictor held in this file.
// Depends on hng_pkg and the RTL of the block under test.
module hysteresis_noise_gate_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // full-scale sample, unity gain in Q1.24, close level 0.00045 of full scale
   localparam longint FS_MAX      = (longint'(1) << (hng_pkg::SAMPLE_W - 1)) - 1;
   localparam longint UNITY_GAIN  = longint'(1) << hng_pkg::GAIN_FRAC;
   localparam longint CLOSE_LEVEL = 3775;

   localparam int SETTLE_CYCLES = 24;    // time allowed for the sequencer to fall back to idle
   localparam int PHASES        = 16;
   localparam int PHASE_ITEMS   = 100;
   localparam int IDLE_PERCENT  = 16;
   localparam int REG_COUNT     = 8;

   // register values after reset, by register index
   localparam logic [hng_pkg::COEF_W-1:0] DEFAULT_SETTING [REG_COUNT] = '{
      24'd1, 24'd216770, 24'd4953342, 24'd231404, 24'd1589, 24'd345898, 24'd1942, 24'd8389
   };

   typedef logic signed [hng_pkg::SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      sample_type gated;
      logic       open;
   } gate_out_type;

   typedef struct {
      longint hp;
      longint lp;
      longint env;
      bit     open;
      longint gain;
   } gate_state_type;

   typedef enum logic [1:0] {
      ROW_PREDICT,   // item, expectation from the predictor
      ROW_TYPED,     // item, expectation written in the row
      ROW_CSR        // register write
   } row_kind_type;

   typedef struct packed {
      row_kind_type                 kind;
      hng_pkg::csr_idx_type         idx;
      logic [hng_pkg::COEF_W-1:0]   value;
      sample_type                   side;
      sample_type                   audio;
      sample_type                   exp_gated;
      logic                         exp_open;
   } stim_row_type;

   // Directed part. Opens with items after reset (gain still zero) and with the gate
   // bypassed, then drives the filters with extreme coefficients: a full-scale step
   // with the high-pass tracker frozen overflows the high-pass difference, the most
   // negative level saturates the rectifier, zero coefficients hold the envelope and
   // the gain, and the open threshold is taken to both its ends.
   localparam stim_row_type DIRECTED [26] = '{
      '{ROW_TYPED, hng_pkg::CSR_GATE_ENABLE, 24'h0, 24'h000000, 24'h7FFFFF, 24'h000000, 1'b0},
      '{ROW_TYPED, hng_pkg::CSR_GATE_ENABLE, 24'h0, 24'h000000, 24'h800000, 24'h000000, 1'b0},
      '{ROW_CSR, hng_pkg::CSR_GATE_ENABLE, 24'hFFFFFE, 24'h0, 24'h0, 24'h0, 1'b0},
      '{ROW_TYPED, hng_pkg::CSR_GATE_ENABLE, 24'h0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0},
      '{ROW_TYPED, hng_pkg::CSR_GATE_ENABLE, 24'h0, 24'h800000, 24'h800000, 24'h800000, 1'b0},
      '{ROW_TYPED, hng_pkg::CSR_GATE_ENABLE, 24'h0, 24'h123456, 24'h000001, 24'h000001, 1'b0},
      '{ROW_CSR, hng_pkg::CSR_GATE_ENABLE, 24'h000001, 24'h0, 24'h0, 24'h0, 1'b0},
      '{ROW_CSR, hng_pkg::CSR_HP_COEF, 24'hFFFFFF, 24'h0, 24'h0, 24'h0, 1'b0},
      '{ROW_CSR, hng_pkg::CSR_LP_COEF, 24'hFFFFFF, 24'h0, 24'h0, 24'h0, 1'b0},
      '{ROW_CSR, hng_pkg::CSR_ATTACK_COEF, 24'hFFFFFF, 24'h0, 24'h0, 24'h0, 1'b0},
      '{ROW_CSR, hng_pkg::CSR_RELEASE_COEF, 24'h000000, 24'h0, 24'h0, 24'h0, 1'b0},
      '{ROW_CSR, hng_pkg::CSR_OPEN_COEF, 24'hFFFFFF, 24'h0, 24'h0, 24'h0, 1'b0},
      '{ROW_CSR, hng_pkg::CSR_CLOSE_COEF, 24'h000000, 24'h0, 24'h0, 24'h0, 1'b0},
      '{ROW_CSR, hng_pkg::CSR_OPEN_THRESHOLD, 24'h000000, 24'h0, 24'h0, 24'h0, 1'b0},
      '{ROW_PREDICT, hng_pkg::CSR_GATE_ENABLE, 24'h0, 24'h7FFFFF, 24'h7FFFFF, 24'h0, 1'b0},
      '{ROW_CSR, hng_pkg::CSR_HP_COEF, 24'h000000, 24'h0, 24'h0, 24'h0, 1'b0},
      '{ROW_PREDICT, hng_pkg::CSR_GATE_ENABLE, 24'h0, 24'h800000, 24'h800000, 24'h0, 1'b0},
      '{ROW_PREDICT, hng_pkg::CSR_GATE_ENABLE, 24'h0, 24'h800000, 24'h7FFFFF, 24'h0, 1'b0},
      '{ROW_CSR, hng_pkg::CSR_OPEN_THRESHOLD, 24'hFFFFFF, 24'h0, 24'h0, 24'h0, 1'b0},
      '{ROW_CSR, hng_pkg::CSR_RELEASE_COEF, 24'hFFFFFF, 24'h0, 24'h0, 24'h0, 1'b0},
      '{ROW_CSR, hng_pkg::CSR_HP_COEF, 24'hFFFFFF, 24'h0, 24'h0, 24'h0, 1'b0},
      '{ROW_PREDICT, hng_pkg::CSR_GATE_ENABLE, 24'h0, 24'h000000, 24'h400000, 24'h0, 1'b0},
      '{ROW_PREDICT, hng_pkg::CSR_GATE_ENABLE, 24'h0, 24'h000000, 24'hC00000, 24'h0, 1'b0},
      '{ROW_CSR, hng_pkg::CSR_CLOSE_COEF, 24'hFFFFFF, 24'h0, 24'h0, 24'h0, 1'b0},
      '{ROW_PREDICT, hng_pkg::CSR_GATE_ENABLE, 24'h0, 24'h000000, 24'h7FFFFF, 24'h0, 1'b0},
      '{ROW_PREDICT, hng_pkg::CSR_GATE_ENABLE, 24'h0, 24'h000001, 24'h800000, 24'h0, 1'b0}
   };

   logic                                clock;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [2*hng_pkg::SAMPLE_W-1:0]      req_tdata  = '0;   // [23:0] sidechain, [47:24] audio
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [hng_pkg::SAMPLE_W-1:0]        rsp_tdata;         // [23:0] gated_sample
   logic                                rsp_tuser;         // [0] gate_is_open
   logic                                csr_valid  = 1'b0;
   logic                                csr_ready;
   logic [hng_pkg::CSR_IDX_W-1:0]       csr_index  = '0;
   logic [hng_pkg::COEF_W-1:0]          csr_data   = '0;

   hysteresis_noise_gate_core dut (.*);

   // predictor copy of the registers and the gate state
   hng_pkg::cfg_type gate_cfg;
   gate_state_type   gate_st = '{0, 0, 0, 1'b0, 0};

   gate_out_type     due_outputs [$];   // expected results, oldest first
   int               failures = 0;
   bit               calm = 1'b0;       // no idling on either side while set

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // one-pole step: R(diff * coef / 2^shift), rounded half away from zero
   function automatic longint scaled_step(longint diff, longint coef, int shift);
      longint mag;
      longint r;
      mag = (diff < 0) ? -diff : diff;
      r = (mag * coef + (longint'(1) << (shift - 1))) >>> shift;
      return (diff < 0) ? -r : r;
   endfunction

   function automatic longint clamp_full_scale(longint v);
      if (v > FS_MAX) return FS_MAX;
      if (v < -FS_MAX - 1) return -FS_MAX - 1;
      return v;
   endfunction

   function automatic void apply_setting(hng_pkg::csr_idx_type idx,
                                         logic [hng_pkg::COEF_W-1:0] v);
      case (idx)
         hng_pkg::CSR_GATE_ENABLE:    gate_cfg.gate_enable    = v[0];
         hng_pkg::CSR_HP_COEF:        gate_cfg.hp_coef        = v;
         hng_pkg::CSR_LP_COEF:        gate_cfg.lp_coef        = v;
         hng_pkg::CSR_ATTACK_COEF:    gate_cfg.attack_coef    = v;
         hng_pkg::CSR_RELEASE_COEF:   gate_cfg.release_coef   = v;
         hng_pkg::CSR_OPEN_COEF:      gate_cfg.open_coef      = v;
         hng_pkg::CSR_CLOSE_COEF:     gate_cfg.close_coef     = v;
         hng_pkg::CSR_OPEN_THRESHOLD: gate_cfg.open_threshold = v[hng_pkg::ENV_W-1:0];
         default: ;
      endcase
   endfunction

   // advances the predicted state by one item and returns the gated sample
   function automatic gate_out_type gate_sample(sample_type side, sample_type audio);
      longint       x;
      longint       hp;
      longint       level;
      longint       target;
      longint       rate;
      gate_out_type r;
      if (!gate_cfg.gate_enable) begin
         // bypass: audio untouched, nothing moves, flag reported as held
         r.gated = audio;
         r.open  = gate_st.open;
         return r;
      end
      x = longint'(side);
      gate_st.hp += scaled_step(x - gate_st.hp, longint'(gate_cfg.hp_coef), hng_pkg::COEF_W);
      hp = clamp_full_scale(x - gate_st.hp);
      gate_st.lp += scaled_step(hp - gate_st.lp, longint'(gate_cfg.lp_coef), hng_pkg::COEF_W);

      level = (gate_st.lp < 0) ? -gate_st.lp : gate_st.lp;
      if (level > FS_MAX) level = FS_MAX;
      rate = (level > gate_st.env) ? longint'(gate_cfg.attack_coef)
                                   : longint'(gate_cfg.release_coef);
      gate_st.env += scaled_step(level - gate_st.env, rate, hng_pkg::COEF_W);

      if (!gate_st.open) gate_st.open = gate_st.env >= longint'(gate_cfg.open_threshold);
      else               gate_st.open = !(gate_st.env < CLOSE_LEVEL);

      // equal target and gain counts as closing
      target = gate_st.open ? UNITY_GAIN : 0;
      rate = (target > gate_st.gain) ? longint'(gate_cfg.open_coef)
                                     : longint'(gate_cfg.close_coef);
      gate_st.gain += scaled_step(target - gate_st.gain, rate, hng_pkg::COEF_W);

      r.gated = sample_type'(clamp_full_scale(scaled_step(longint'(audio), gate_st.gain,
                                                          hng_pkg::GAIN_FRAC)));
      r.open  = gate_st.open;
      return r;
   endfunction

   // Random register value. Extremes and the slow, realistic end of the
   // coefficient range get extra weight; thresholds sit mostly where the
   // envelope can reach them. Spare upper bits are random to check masking.
   function automatic logic [hng_pkg::COEF_W-1:0] pick_setting(hng_pkg::csr_idx_type idx);
      int unsigned                roll;
      logic [hng_pkg::COEF_W-1:0] v;
      roll = $urandom_range(0, 9);
      case (idx)
         hng_pkg::CSR_GATE_ENABLE: begin
            v = hng_pkg::COEF_W'($urandom);
            v[0] = (roll != 0);
         end
         hng_pkg::CSR_OPEN_THRESHOLD: begin
            if (roll == 0)      v = '0;
            else if (roll == 1) v = '1;
            else if (roll < 6)  v = hng_pkg::COEF_W'($urandom_range(0, 20000));
            else                v = hng_pkg::COEF_W'($urandom_range(0, 400000));
            if (roll > 1) v[hng_pkg::COEF_W-1] = 1'($urandom_range(0, 1));
         end
         default: begin
            if (roll == 0)      v = '0;
            else if (roll == 1) v = '1;
            else if (roll < 4)  v = hng_pkg::COEF_W'($urandom_range(0, 1 << 16));
            else if (roll < 6)  v = hng_pkg::COEF_W'($urandom_range(0, 1 << 20));
            else                v = hng_pkg::COEF_W'($urandom);
         end
      endcase
      return v;
   endfunction

   // Hold off the sender until every result is in, then give the
   // sequencer time to fall back to idle.
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (due_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register writes only ever happen on an idle block
   task automatic write_register(hng_pkg::csr_idx_type idx,
                                 logic [hng_pkg::COEF_W-1:0] value);
      quiesce();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_setting(idx, value);
   endtask

   // Offers one item, with random gaps ahead of it. The predictor is
   // stepped at the accepting edge; a typed expectation replaces its result.
   task automatic send_item(sample_type side, sample_type audio, bit typed,
                            gate_out_type typed_out);
      gate_out_type predicted;
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {audio, side};
      do @(posedge clock); while (!req_tready);
      predicted = gate_sample(side, audio);
      due_outputs.push_back(typed ? typed_out : predicted);
   endtask

   // Result side: checks each accepted item against the oldest expectation
   // and stalls at random. Values are sampled before this edge's updates.
   always @(posedge clock) begin : collect
      gate_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_outputs.size() == 0) begin
            $error("result with nothing expected: gated_sample %0d, gate_is_open %0d",
                   $signed(rsp_tdata), rsp_tuser);
            failures++;
         end else begin
            want = due_outputs.pop_front();
            if (rsp_tdata !== want.gated) begin
               $error("gated_sample: expected %0d, got %0d", want.gated, $signed(rsp_tdata));
               failures++;
            end
            if (rsp_tuser !== want.open) begin
               $error("gate_is_open: expected %0d, got %0d", want.open, rsp_tuser);
               failures++;
            end
         end
      end
      rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   initial begin : stimulus
      stim_row_type row;
      gate_out_type typed_out;
      int           seg_left;
      int unsigned  mode;
      sample_type   side;
      sample_type   audio;

      foreach (DEFAULT_SETTING[i])
         apply_setting(hng_pkg::csr_idx_type'(i), DEFAULT_SETTING[i]);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         row = DIRECTED[i];
         typed_out.gated = row.exp_gated;
         typed_out.open  = row.exp_open;
         if (row.kind == ROW_CSR) write_register(row.idx, row.value);
         else send_item(row.side, row.audio, row.kind == ROW_TYPED, typed_out);
      end

      // Random phases: every register rewritten on an idle block, the first
      // phase back at reset values, a few phases in the middle without idling.
      // The sidechain comes in bursts (noise, near silence, silence, rail to
      // rail squares) so the gate keeps opening and closing.
      for (int p = 0; p < PHASES; p++) begin
         for (int r = 0; r < REG_COUNT; r++)
            write_register(hng_pkg::csr_idx_type'(r),
                           (p == 0) ? DEFAULT_SETTING[r]
                                    : pick_setting(hng_pkg::csr_idx_type'(r)));
         calm = (p >= 5 && p < 8);
         seg_left = 0;
         repeat (PHASE_ITEMS) begin
            if (seg_left == 0) begin
               mode     = $urandom_range(0, 3);
               seg_left = $urandom_range(4, 40);
            end
            seg_left--;
            case (mode)
               0:       side = sample_type'($urandom);
               1:       side = sample_type'(longint'($urandom_range(0, 2000)) - 1000);
               2:       side = '0;
               default: side = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            endcase
            audio = sample_type'($urandom);
            send_item(side, audio, 1'b0, '0);
         end
         calm = 1'b0;
      end

      quiesce();
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
